@@ rtl/eit_pkg.sv @@
//------------------------------------------------------------------------------
// eit_pkg
// types, constants and status codes shared by the event interest table
//------------------------------------------------------------------------------
`default_nettype none
package eit_pkg;
    localparam int INST_CNT = 16;
    localparam int SLOT_CNT = 64;
    localparam int INST_W = $clog2(INST_CNT);
    localparam int SLOT_W = $clog2(SLOT_CNT);
    localparam int ADDR_W = INST_W + SLOT_W;

    localparam logic [2:0] MODE_CREATE = 3'd0;
    localparam logic [2:0] MODE_ADD    = 3'd1;
    localparam logic [2:0] MODE_MOD    = 3'd2;
    localparam logic [2:0] MODE_DEL    = 3'd3;
    localparam logic [2:0] MODE_CLOSE  = 3'd4;
    localparam logic [2:0] MODE_REF    = 3'd5;

    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_INVALID  = 3'd1;
    localparam logic [2:0] ST_EXISTS   = 3'd2;
    localparam logic [2:0] ST_NOSLOT   = 3'd3;
    localparam logic [2:0] ST_NOTFOUND = 3'd4;
    localparam logic [2:0] ST_POOLFULL = 3'd5;

    typedef struct packed {
        logic [2:0]  mode;
        logic [3:0]  instance_req;
        logic [15:0] descriptor;
        logic [31:0] event_mask;
        logic [63:0] user_data;
    } req_t;

    typedef struct packed {
        logic [2:0] status;
        logic [3:0] new_instance;
    } rsp_t;

    // one slot entry as stored in the slot memory
    typedef struct packed {
        logic        valid;
        logic [15:0] descriptor;
        logic [31:0] events;
        logic [63:0] payload;
    } slot_t;

    // per-instance header entry
    typedef struct packed {
        logic        used;
        logic [15:0] refs;
        logic [6:0]  interests;
    } hdr_t;

    // slot memory port bundle
    typedef struct packed {
        logic              rd;
        logic              wr;
        logic [ADDR_W-1:0] addr;
        slot_t             wdata;
    } slot_cmd_t;

    // header memory port bundle
    typedef struct packed {
        logic              rd;
        logic              wr;
        logic [INST_W-1:0] addr;
        hdr_t              wdata;
    } hdr_cmd_t;
endpackage
`default_nettype wire

@@ rtl/eit_slot_mem.sv @@
//------------------------------------------------------------------------------
// eit_slot_mem
// slot table storage, one port, registered read data
//------------------------------------------------------------------------------
`default_nettype none
module eit_slot_mem
    import eit_pkg::*;
(
    input  wire logic      clk,
    input  wire slot_cmd_t cmd,
    output slot_t          rdata
);
    slot_t mem [INST_CNT*SLOT_CNT];

    always_ff @(posedge clk)
    begin
        if (cmd.wr)
        begin
            mem[cmd.addr] <= cmd.wdata;
        end
        if (cmd.rd)
        begin
            rdata <= mem[cmd.addr];
        end
    end
endmodule
`default_nettype wire

@@ rtl/eit_hdr_mem.sv @@
//------------------------------------------------------------------------------
// eit_hdr_mem
// instance header storage, one port, registered read data
//------------------------------------------------------------------------------
`default_nettype none
module eit_hdr_mem
    import eit_pkg::*;
(
    input  wire logic     clk,
    input  wire hdr_cmd_t cmd,
    output hdr_t          rdata
);
    hdr_t mem [INST_CNT];

    always_ff @(posedge clk)
    begin
        if (cmd.wr)
        begin
            mem[cmd.addr] <= cmd.wdata;
        end
        if (cmd.rd)
        begin
            rdata <= mem[cmd.addr];
        end
    end
endmodule
`default_nettype wire

@@ rtl/eit_ctrl.sv @@
//------------------------------------------------------------------------------
// eit_ctrl
// sequencer: scans headers and slots one entry a cycle, writes back
//------------------------------------------------------------------------------
`default_nettype none
module eit_ctrl
    import eit_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire logic  start,
    input  wire req_t  req,
    output logic       busy,
    output logic       done,
    output rsp_t       rsp,
    output slot_cmd_t  scmd,
    input  wire slot_t srd,
    output hdr_cmd_t   hcmd,
    input  wire hdr_t  hrd
);
    localparam logic [3:0] S_INIT  = 4'd0;  // clear header memory after reset
    localparam logic [3:0] S_IDLE  = 4'd1;
    localparam logic [3:0] S_HRD   = 4'd2;  // header read issued
    localparam logic [3:0] S_HCHK  = 4'd3;  // header data present
    localparam logic [3:0] S_CSCAN = 4'd4;  // create: header scan
    localparam logic [3:0] S_CLR   = 4'd5;  // create: slot clear sweep
    localparam logic [3:0] S_SSCAN = 4'd6;  // slot scan
    localparam logic [3:0] S_FIN   = 4'd7;
    localparam logic [3:0] S_RESP  = 4'd8;

    logic [3:0]        state_reg, state_next;
    req_t              req_reg;
    hdr_t              hdr_reg, hdr_next;
    logic [INST_W:0]   icnt_reg, icnt_next;
    logic [SLOT_W:0]   scnt_reg, scnt_next;   // slot read index
    logic              hit_reg, hit_next;
    logic [SLOT_W-1:0] hidx_reg, hidx_next;
    logic              free_reg, free_next;
    logic [SLOT_W-1:0] fidx_reg, fidx_next;
    logic [2:0]        status_reg, status_next;
    logic [INST_W-1:0] alloc_reg, alloc_next;
    logic              pend_reg, pend_next;   // slot or header read data valid
    logic [SLOT_W-1:0] pidx_reg, pidx_next;
    logic [INST_W-1:0] inst;

    assign inst = req_reg.instance_req[INST_W-1:0];
    assign busy = (state_reg != S_IDLE);
    assign done = (state_reg == S_RESP);
    assign rsp.status = status_reg;
    assign rsp.new_instance = 4'(alloc_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_INIT;
            icnt_reg  <= '0;
            pend_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            icnt_reg  <= icnt_next;
            pend_reg  <= pend_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start && !busy)
        begin
            req_reg <= req;
        end
        hdr_reg    <= hdr_next;
        scnt_reg   <= scnt_next;
        hit_reg    <= hit_next;
        hidx_reg   <= hidx_next;
        free_reg   <= free_next;
        fidx_reg   <= fidx_next;
        status_reg <= status_next;
        alloc_reg  <= alloc_next;
        pidx_reg   <= pidx_next;
    end

    always_comb
    begin
        state_next  = state_reg;
        hdr_next    = hdr_reg;
        icnt_next   = icnt_reg;
        scnt_next   = scnt_reg;
        hit_next    = hit_reg;
        hidx_next   = hidx_reg;
        free_next   = free_reg;
        fidx_next   = fidx_reg;
        status_next = status_reg;
        alloc_next  = alloc_reg;
        pend_next   = 1'b0;
        pidx_next   = pidx_reg;
        scmd        = '0;
        hcmd        = '0;
        unique case (state_reg)
            S_INIT:
            begin
                hcmd.wr   = 1'b1;
                hcmd.addr = icnt_reg[INST_W-1:0];
                icnt_next = icnt_reg + 1'b1;
                if (icnt_reg == (INST_W+1)'(INST_CNT - 1))
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (start)
                begin
                    alloc_next = '0;
                    icnt_next  = '0;
                    scnt_next  = '0;
                    hit_next   = 1'b0;
                    free_next  = 1'b0;
                    hidx_next  = '0;
                    fidx_next  = '0;
                    if (req.mode == MODE_CREATE)
                    begin
                        state_next = S_CSCAN;
                    end
                    else if (req.mode > MODE_REF
                             || {1'b0, req.instance_req} >= 5'(INST_CNT))
                    begin
                        status_next = ST_INVALID;
                        state_next  = S_RESP;
                    end
                    else
                    begin
                        hcmd.rd    = 1'b1;
                        hcmd.addr  = req.instance_req[INST_W-1:0];
                        state_next = S_HRD;
                    end
                end
            end
            S_CSCAN:
            begin
                // read header i, then check it when data returns
                if (pend_reg)
                begin
                    if (!hrd.used)
                    begin
                        alloc_next = pidx_reg[INST_W-1:0];
                        state_next = S_CLR;
                        scnt_next  = '0;
                    end
                    else if (icnt_reg == (INST_W+1)'(INST_CNT))
                    begin
                        status_next = ST_POOLFULL;
                        state_next  = S_RESP;
                    end
                end
                if (state_next == S_CSCAN && icnt_reg != (INST_W+1)'(INST_CNT))
                begin
                    hcmd.rd   = 1'b1;
                    hcmd.addr = icnt_reg[INST_W-1:0];
                    pidx_next = SLOT_W'(icnt_reg[INST_W-1:0]);
                    pend_next = 1'b1;
                    icnt_next = icnt_reg + 1'b1;
                end
            end
            S_CLR:
            begin
                scmd.wr   = 1'b1;
                scmd.addr = {alloc_reg, scnt_reg[SLOT_W-1:0]};
                scnt_next = scnt_reg + 1'b1;
                if (scnt_reg == (SLOT_W+1)'(SLOT_CNT - 1))
                begin
                    hcmd.wr     = 1'b1;
                    hcmd.addr   = alloc_reg;
                    hcmd.wdata  = '{used: 1'b1, refs: 16'd1, interests: 7'd0};
                    status_next = ST_OK;
                    state_next  = S_RESP;
                end
            end
            S_HRD:
            begin
                state_next = S_HCHK;
            end
            S_HCHK:
            begin
                hdr_next = hrd;
                if (!hrd.used)
                begin
                    status_next = ST_INVALID;
                    state_next  = S_RESP;
                end
                else if (req_reg.mode == MODE_CLOSE)
                begin
                    hcmd.wr    = 1'b1;
                    hcmd.addr  = inst;
                    hcmd.wdata = hrd;
                    if (hrd.refs <= 16'd1)
                    begin
                        hcmd.wdata = '0;
                    end
                    else
                    begin
                        hcmd.wdata.refs = hrd.refs - 1'b1;
                    end
                    status_next = ST_OK;
                    state_next  = S_RESP;
                end
                else if (req_reg.mode == MODE_REF)
                begin
                    hcmd.wr    = 1'b1;
                    hcmd.addr  = inst;
                    hcmd.wdata = hrd;
                    if (hrd.refs != 16'hFFFF)
                    begin
                        hcmd.wdata.refs = hrd.refs + 1'b1;
                    end
                    status_next = ST_OK;
                    state_next  = S_RESP;
                end
                else
                begin
                    state_next = S_SSCAN;
                end
            end
            S_SSCAN:
            begin
                if (pend_reg)
                begin
                    if (srd.valid && srd.descriptor == req_reg.descriptor && !hit_next)
                    begin
                        hit_next  = 1'b1;
                        hidx_next = pidx_reg;
                    end
                    if (!srd.valid && !free_next)
                    begin
                        free_next = 1'b1;
                        fidx_next = pidx_reg;
                    end
                end
                if (scnt_reg != (SLOT_W+1)'(SLOT_CNT))
                begin
                    scmd.rd   = 1'b1;
                    scmd.addr = {inst, scnt_reg[SLOT_W-1:0]};
                    pidx_next = scnt_reg[SLOT_W-1:0];
                    pend_next = 1'b1;
                    scnt_next = scnt_reg + 1'b1;
                end
                else if (!pend_reg)
                begin
                    state_next = S_FIN;
                end
            end
            S_FIN:
            begin
                status_next = ST_OK;
                state_next  = S_RESP;
                hcmd.addr   = inst;
                hcmd.wdata  = hdr_reg;
                case (req_reg.mode)
                    MODE_ADD:
                    begin
                        if (hit_reg)
                        begin
                            status_next = ST_EXISTS;
                        end
                        else if (!free_reg)
                        begin
                            status_next = ST_NOSLOT;
                        end
                        else
                        begin
                            scmd.wr    = 1'b1;
                            scmd.addr  = {inst, fidx_reg};
                            scmd.wdata = '{valid: 1'b1, descriptor: req_reg.descriptor,
                                           events: req_reg.event_mask,
                                           payload: req_reg.user_data};
                            hcmd.wr    = 1'b1;
                            if (hdr_reg.interests != 7'd127)
                            begin
                                hcmd.wdata.interests = hdr_reg.interests + 1'b1;
                            end
                        end
                    end
                    MODE_MOD:
                    begin
                        if (!hit_reg)
                        begin
                            status_next = ST_NOTFOUND;
                        end
                        else
                        begin
                            scmd.wr    = 1'b1;
                            scmd.addr  = {inst, hidx_reg};
                            scmd.wdata = '{valid: 1'b1, descriptor: req_reg.descriptor,
                                           events: req_reg.event_mask,
                                           payload: req_reg.user_data};
                        end
                    end
                    default:
                    begin
                        if (!hit_reg)
                        begin
                            status_next = ST_NOTFOUND;
                        end
                        else
                        begin
                            scmd.wr    = 1'b1;
                            scmd.addr  = {inst, hidx_reg};
                            scmd.wdata = '0;
                            hcmd.wr    = 1'b1;
                            if (hdr_reg.interests != 7'd0)
                            begin
                                hcmd.wdata.interests = hdr_reg.interests - 1'b1;
                            end
                        end
                    end
                endcase
            end
            S_RESP:
            begin
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end
endmodule
`default_nettype wire

@@ rtl/event_interest_table.sv @@
// create scans the headers, then sweeps the new instance's slots clear;
// add/modify/delete read one slot per cycle over all 64 slots;
// close/ref act on the header alone; one item at a time, busy high meanwhile
// after reset a pass over all 16 headers clears the header memory with busy high
// results appear for one cycle on done; the receiver cannot stall
//------------------------------------------------------------------------------
// event_interest_table
// pool of event interest instances with per-instance slot tables
//------------------------------------------------------------------------------
`default_nettype none
module event_interest_table
    import eit_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic start,
    input  wire req_t req,
    output logic      busy,
    output logic      done,
    output rsp_t      rsp
);
    slot_cmd_t scmd;
    slot_t     srd;
    hdr_cmd_t  hcmd;
    hdr_t      hrd;

    eit_ctrl u_ctrl (
        .clk(clk), .rst_n(rst_n), .start(start), .req(req), .busy(busy),
        .done(done), .rsp(rsp), .scmd(scmd), .srd(srd), .hcmd(hcmd), .hrd(hrd)
    );

    eit_slot_mem u_slot (.clk(clk), .cmd(scmd), .rdata(srd));
    eit_hdr_mem  u_hdr  (.clk(clk), .cmd(hcmd), .rdata(hrd));
endmodule
`default_nettype wire

@@ rtl/eit_checker.sv @@
//------------------------------------------------------------------------------
// eit_checker
// port-level checks on the event interest table
//------------------------------------------------------------------------------
`default_nettype none
module eit_checker
    import eit_pkg::*;
(
    input wire logic clk,
    input wire logic rst_n,
    input wire logic start,
    input wire logic busy,
    input wire logic done,
    input wire rsp_t rsp
);
    a_done_busy: assert property (@(posedge clk) disable iff (!rst_n) done |-> busy)
        else $error("done without busy");
    a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n) done |=> !done)
        else $error("done longer than one cycle");
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("item accepted but not busy");
    a_alloc_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && rsp.status != ST_OK) |-> rsp.new_instance == 4'd0)
        else $error("allocation on failure");
endmodule

bind event_interest_table eit_checker u_chk (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .done(done), .rsp(rsp)
);
`default_nettype wire
